// ===== design/pending_interest_table_core_macros.svh =====
// Assertion macros used by the pending interest table core.
`ifndef PENDING_INTEREST_TABLE_CORE_MACROS_SVH
`define PENDING_INTEREST_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PIT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pit_pkg.sv =====
// Shared constants, codes and entry type of the pending interest table.
`timescale 1ns / 1ps
package pit_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int HASH_BYTES  = 8;

  localparam int NAME_W  = 64;
  localparam int HASH_W  = HASH_BYTES * 8;
  localparam int NONCE_W = 32;
  localparam int IP_W    = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam int IN_DATA_W  = ((NAME_W + NONCE_W + IP_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IP_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INTEREST = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_SWEEP    = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_MATCH     = 3'd3,
    ST_NOMATCH   = 3'd4,
    ST_SWEPT     = 3'd5
  } status_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [NONCE_W-1:0] nonce;
    logic [IP_W-1:0]    addr;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

endpackage

// ===== design/pit_ram.sv =====
// Entry payload memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pit_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [pit_pkg::IDX_W-1:0] wr_addr,
  input  pit_pkg::entry_t         wr_data,
  input  logic [pit_pkg::IDX_W-1:0] rd_addr,
  output pit_pkg::entry_t         rd_data
);
  import pit_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/pending_interest_table_core.sv =====
// Top level of the pending interest table: sequencer, valid bits and result register.
`timescale 1ns / 1ps
`include "pending_interest_table_core_macros.svh"
// Pending interest table. Holds TABLE_DEPTH pending interests; the hash, nonce,
// sender address and time stamp of each entry live in a synchronous memory,
// the valid bits in flip-flops cleared by reset (the table starts empty, no
// clearing pass). Each item walks the whole table through the single memory
// read port, one entry per cycle unless a stall holds the walk; a new item is
// taken only in the idle state, once the previous item is finished. A data item
// that matches several entries stalls its walk while the result register is
// still occupied by an earlier match. Kind 0 inserts an
// interest (full, duplicate or inserted into the lowest free slot), kind 1
// consumes every valid entry whose hash matches, one result each in index
// order with tlast on the final one (or a single no-match result), kind 2
// frees every entry whose wrapping age exceeds ttl_ms and reports the count.
// Kind 3 is dropped without a result. The result register decouples the two
// sides: a new item is taken while the previous result still waits.
module pending_interest_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: ttl_ms
  input  logic                          cfg_tvalid,
  output logic                          cfg_tready,
  input  logic [pit_pkg::TIME_W-1:0]    cfg_tdata,
  // input item
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pit_pkg::IN_DATA_W-1:0] in_tdata,   // name_hash, nonce, source_ip, now_ms
  input  logic [pit_pkg::KIND_W-1:0]    in_tuser,   // kind
  // result item
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pit_pkg::OUT_DATA_W-1:0] out_tdata, // dest_ip, expired_count, zero pad
  output logic [pit_pkg::STAT_W-1:0]    out_tuser,  // status
  output logic                          out_tlast   // last
);
  import pit_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       issue_r, issue_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]       p_idx_r, p_idx_nxt;
  logic                   dup_r, dup_nxt;
  logic                   pend_r, pend_nxt;
  logic [COUNT_W-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic [TIME_W-1:0]      ttl_r, ttl_nxt;

  // captured item
  kind_t                  kind_r, kind_nxt;
  logic [HASH_W-1:0]      hash_r, hash_nxt;
  logic [NONCE_W-1:0]     nonce_r, nonce_nxt;
  logic [IP_W-1:0]        src_r, src_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [IP_W-1:0]        pend_ip_r, pend_ip_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [IP_W-1:0]        out_dest_r, out_dest_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                   out_last_r, out_last_nxt;

  // datapath
  entry_t                 rd_q;
  entry_t                 wr_entry;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       free_idx;
  logic [TIME_W-1:0]      age;
  logic                   in_acc;
  logic                   out_free;
  logic                   ent_v;
  logic                   hash_eq;
  logic                   data_hit;
  logic                   scan_push;
  logic                   stall;
  logic                   issue_more;
  logic                   full;
  logic                   mem_we;

  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_W'({out_count_r, out_dest_r});
  assign out_free   = !out_valid_r || out_tready;

  // Evaluate the entry whose read data just came back.
  assign ent_v   = valid_r[p_idx_r];
  assign hash_eq = (rd_q.hash == hash_r);
  assign age     = now_r - rd_q.stamp;

  assign data_hit  = (state_r == S_SCAN) && p_vld_r && (kind_r == KIND_DATA) && ent_v && hash_eq;
  // A new match flushes the held match, which is then known not to be the last.
  assign scan_push = data_hit && pend_r;
  assign stall     = scan_push && !out_free;

  assign issue_more = (issue_r != CNT_W'(TABLE_DEPTH));
  // On a stall re-read the entry under evaluation so its data holds.
  assign rd_addr    = stall ? p_idx_r : issue_r[IDX_W-1:0];

  assign full = &valid_r;

  always_comb begin
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign mem_we = (state_r == S_DONE) && out_free && (kind_r == KIND_INTEREST) &&
                  !full && !dup_r;

  assign wr_entry.hash  = hash_r;
  assign wr_entry.nonce = nonce_r;
  assign wr_entry.addr  = src_r;
  assign wr_entry.stamp = now_r;

  pit_ram u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (free_idx),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    issue_nxt      = issue_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    dup_nxt        = dup_r;
    pend_nxt       = pend_r;
    pend_ip_nxt    = pend_ip_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    ttl_nxt        = ttl_r;
    kind_nxt       = kind_r;
    hash_nxt       = hash_r;
    nonce_nxt      = nonce_r;
    src_nxt        = src_r;
    now_nxt        = now_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_dest_nxt   = out_dest_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    if (cfg_tvalid && cfg_tready) begin
      ttl_nxt = cfg_tdata;
    end

    // drop the result once taken; a push below overrides
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt      = kind_t'(in_tuser);
          hash_nxt      = in_tdata[HASH_W-1:0];
          nonce_nxt     = in_tdata[NAME_W +: NONCE_W];
          src_nxt       = in_tdata[NAME_W + NONCE_W +: IP_W];
          now_nxt       = in_tdata[NAME_W + NONCE_W + IP_W +: TIME_W];
          issue_nxt     = '0;
          p_vld_nxt     = 1'b0;
          dup_nxt       = 1'b0;
          pend_nxt      = 1'b0;
          sweep_cnt_nxt = '0;
          // kind 3 stays idle: no walk, no result
          if (in_tuser == KIND_INTEREST || in_tuser == KIND_DATA ||
              in_tuser == KIND_SWEEP) begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (p_vld_r) begin
            unique case (kind_r)
              KIND_INTEREST: begin
                if (ent_v && hash_eq && (rd_q.nonce == nonce_r)) begin
                  dup_nxt = 1'b1;
                end
              end
              KIND_DATA: begin
                if (data_hit) begin
                  valid_nxt[p_idx_r] = 1'b0;
                  pend_nxt           = 1'b1;
                  pend_ip_nxt        = rd_q.addr;
                end
              end
              KIND_SWEEP: begin
                if (ent_v && (age > ttl_r)) begin
                  valid_nxt[p_idx_r] = 1'b0;
                  sweep_cnt_nxt      = sweep_cnt_r + COUNT_W'(1);
                end
              end
              default: begin
              end
            endcase
          end
          if (issue_more) begin
            p_vld_nxt = 1'b1;
            p_idx_nxt = issue_r[IDX_W-1:0];
            issue_nxt = issue_r + CNT_W'(1);
          end else begin
            p_vld_nxt = 1'b0;
            // last entry evaluated this cycle: report next
            state_nxt = S_DONE;
          end
        end
        if (scan_push && out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_MATCH;
          out_dest_nxt   = pend_ip_r;
          out_count_nxt  = '0;
          out_last_nxt   = 1'b0;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dest_nxt  = '0;
          out_count_nxt = '0;
          out_last_nxt  = 1'b1;
          unique case (kind_r)
            KIND_INTEREST: begin
              // full wins over duplicate
              if (full) begin
                out_status_nxt = ST_FULL;
              end else if (dup_r) begin
                out_status_nxt = ST_DUPLICATE;
              end else begin
                out_status_nxt      = ST_INSERTED;
                valid_nxt[free_idx] = 1'b1;
              end
            end
            KIND_DATA: begin
              if (pend_r) begin
                out_status_nxt = ST_MATCH;
                out_dest_nxt   = pend_ip_r;
              end else begin
                out_status_nxt = ST_NOMATCH;
              end
            end
            KIND_SWEEP: begin
              out_status_nxt = ST_SWEPT;
              out_count_nxt  = sweep_cnt_r;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      p_vld_r     <= 1'b0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
      ttl_r       <= TIME_W'(1000);
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      p_vld_r     <= p_vld_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      ttl_r       <= ttl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r      <= p_idx_nxt;
    dup_r        <= dup_nxt;
    pend_r       <= pend_nxt;
    pend_ip_r    <= pend_ip_nxt;
    sweep_cnt_r  <= sweep_cnt_nxt;
    kind_r       <= kind_nxt;
    hash_r       <= hash_nxt;
    nonce_r      <= nonce_nxt;
    src_r        <= src_nxt;
    now_r        <= now_nxt;
    out_status_r <= out_status_nxt;
    out_dest_r   <= out_dest_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  // No read in flight while waiting for an item.
  `PIT_ASSERT_IMP(a_idle_no_read, clk, rst_n, state_r == S_IDLE, !p_vld_r, "read in flight while idle")
  // An insert only ever lands in a free slot of a table that is not full.
  `PIT_ASSERT_IMP(a_write_free_slot, clk, rst_n, mem_we, !valid_r[free_idx] && !full, "insert into occupied slot")
  // The inserted slot is valid after the write.
  `PIT_ASSERT_NXT(a_insert_valid, clk, rst_n, mem_we, valid_r[$past(free_idx)], "inserted slot not valid")
  // Mid-walk results come only from a data item holding an earlier match.
  `PIT_ASSERT_IMP(a_scan_push_data, clk, rst_n, scan_push, kind_r == KIND_DATA && pend_r, "stray match result")
  // A sweep never frees more entries than the table holds.
  `PIT_ASSERT_IMP(a_sweep_bound, clk, rst_n, state_r == S_DONE && kind_r == KIND_SWEEP, sweep_cnt_r <= COUNT_W'(TABLE_DEPTH), "sweep count too large")

endmodule
